@@ design/tmcw_pkg.sv @@
// Shared types, constants and helpers for the text-mode console writer.
package tmcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam int CODE_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int POS_W       = 11;
    localparam int WORD_W      = 16;
    localparam int ACTION_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    // action codes on the input tuser
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // character codes
    localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h0F;

    // job classes handed from the front end to the back end
    typedef enum logic [2:0] {
        K_NOP,
        K_BACKSPACE,
        K_TAB,
        K_NEWLINE,
        K_PRINT,
        K_CLEAR,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CODE_W-1:0]   code;
        logic [ATTR_W-1:0]   attr;
        logic [INDEX_W-1:0]  index;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_head;

    function automatic logic [WORD_W-1:0] blank_word(input logic [ATTR_W-1:0] attr);
        return {attr, CH_SPACE};
    endfunction

endpackage

@@ design/text_mode_console_writer_unit.sv @@
// Top level of the text-mode console writer: config register, front end, back end.
// Usage notes
// - Input stream (s_axis_*): one transfer per action. tuser carries the action
//   (0 put character, 1 clear screen, 2 read cell); tdata carries the character,
//   background and foreground colours and the cell index for reads.
// - Output stream (m_axis_*): exactly one result transfer per input transfer, in
//   order: the linear cursor position after the action and, for reads, the cell
//   word (attribute in the high byte, character in the low byte), else zero.
// - Config channel (i_cfg_*): the blank attribute used by clear and scroll; it is
//   always ready and should only be written while the block is idle.
// - A put or ignored code is registered in the job queue, then the result
//   register; a read also passes the registered read port of the screen RAM and
//   holds off the next job; sustained rate is one put per cycle unless stalled.
// - A scroll walks the screen RAM with one read and one write per cycle; a clear
//   writes one cell per cycle. A two-deep job queue takes up to two more transfers
//   meanwhile.
// - Reset: the RAM is swept to blanks with attribute 0x0F, and s_axis_tready
//   stays low until the sweep is over.
// - Output stalls: the result register holds its transfer; the back end stops
//   issuing, the queue fills and then s_axis_tready drops.
module text_mode_console_writer_unit #(
    parameter int COLUMNS   = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tmcw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tmcw_pkg::DEF_TAB_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // char_code[7:0], bg_colour[11:8],
                                        // fg_colour[15:12], cell_index[26:16]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cursor_position[10:0], cell_word[26:11]
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data      // blank_attribute
);
    import tmcw_pkg::*;

    logic [ATTR_W-1:0] r_blank_attr;
    t_queue_head       head;
    logic              pop;
    logic              init_busy;
    logic              queue_full;

    // config register: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= BLANK_ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_blank_attr <= i_cfg_data;
        end
    end

    // front end: accept, classify, queue
    tmcw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold        (init_busy),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head        (head),
        .i_pop         (pop),
        .o_full        (queue_full)
    );

    // back end: cursor, screen RAM, scroll/clear sweeps, result register
    tmcw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_blank_attr  (r_blank_attr),
        .o_init_busy   (init_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // no input transfer while the reset sweep runs
    a_init_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !s_axis_tready)
        else $error("input accepted during reset sweep");

    // the reset sweep produces no result
    a_init_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !m_axis_tvalid)
        else $error("result presented during reset sweep");

    // a full queue must back-pressure the input
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_full |-> !s_axis_tready)
        else $error("input ready with job queue full");

    // the reset sweep runs once only
    a_init_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !init_busy |=> !init_busy)
        else $error("reset sweep restarted");

endmodule

@@ design/tmcw_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/tmcw_front.sv @@
// Front end: takes input transfers, classifies them and queues jobs.
module tmcw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_hold,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,  // char_code, bg_colour, fg_colour, cell_index
    input  logic [1:0]           s_axis_tuser,  // action
    output tmcw_pkg::t_queue_head o_head,
    input  logic                 i_pop,
    output logic                 o_full
);
    import tmcw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             job;
    logic [CODE_W-1:0] code;
    logic             accept;

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign code = s_axis_tdata[7:0];

    always_comb begin
        job.code  = code;
        job.attr  = {s_axis_tdata[11:8], s_axis_tdata[15:12]};
        job.index = s_axis_tdata[26:16];
        case (s_axis_tuser)
            ACT_PUT: begin
                case (code)
                    CH_BACKSPACE: job.kind = K_BACKSPACE;
                    CH_TAB:       job.kind = K_TAB;
                    CH_CR, CH_LF: job.kind = K_NEWLINE;
                    default: begin
                        // printable range is 0x20..0x7F
                        job.kind = (!code[7] && code >= CH_SPACE) ? K_PRINT : K_NOP;
                    end
                endcase
            end
            ACT_CLEAR: job.kind = K_CLEAR;
            ACT_READ:  job.kind = K_READ;
            default:   job.kind = K_NOP;
        endcase
    end

    assign o_full        = (r_count == CNT_W'(QUEUE_DEPTH));
    assign s_axis_tready = !o_full && !i_hold;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_ptr] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({accept, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/tmcw_back.sv @@
// Back end: cursor, screen store, scroll and clear sequencing, result register.
module tmcw_back #(
    parameter int COLUMNS   = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tmcw_pkg::DEF_ROWS,
    parameter int TAB_WIDTH = tmcw_pkg::DEF_TAB_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tmcw_pkg::t_queue_head i_head,
    output logic                 o_pop,
    input  logic [7:0]           i_blank_attr,
    output logic                 o_init_busy,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata   // cursor_position, cell_word
);
    import tmcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int SCROLL_END = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int PH_W       = $clog2(TAB_WIDTH);
    localparam int WIDE_W     = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int OUT_PAD    = 32 - POS_W - WORD_W;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [WORD_W-1:0]   r_fill_word;
    logic                r_fill_reply;
    logic                r_init;
    logic                r_read_ok;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [ADDR_W-1:0]   r_base;
    logic [PH_W-1:0]     r_phase;
    logic                r_out_valid;
    logic [POS_W-1:0]    r_out_pos;
    logic [WORD_W-1:0]   r_out_word;

    t_job                job;
    logic                pop;
    logic                out_free;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   nxt_addr;
    logic [WIDE_W-1:0]   cur_wide;
    logic [WIDE_W-1:0]   nxt_wide;
    logic [WIDE_W-1:0]   idx_wide;
    logic                idx_ok;

    // put-character outcome
    logic                put_wr;
    logic [ADDR_W-1:0]   put_addr;
    logic [WORD_W-1:0]   put_data;
    logic [COL_W-1:0]    col_step;
    logic [PH_W-1:0]     ph_step;
    logic                line;
    logic [COL_W-1:0]    n_col;
    logic [PH_W-1:0]     n_phase;
    logic [ROW_W-1:0]    n_row;
    logic [ADDR_W-1:0]   n_base;
    logic                n_scroll;

    // memory ports
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic [CNT_W-1:0]    scroll_src;
    logic [CNT_W-1:0]    scroll_dst;

    assign job      = i_head.job;
    assign out_free = !r_out_valid || m_axis_tready;
    assign pop      = (r_state == S_IDLE) && i_head.valid && out_free;
    assign o_pop    = pop;

    assign cur_addr = r_base + ADDR_W'(r_col);
    assign nxt_addr = n_base + ADDR_W'(n_col);
    assign cur_wide = WIDE_W'(cur_addr);
    assign nxt_wide = WIDE_W'(nxt_addr);
    assign idx_wide = WIDE_W'(job.index);
    assign idx_ok   = idx_wide < WIDE_W'(CELL_COUNT);

    assign scroll_src = r_cnt + CNT_W'(COLUMNS);
    assign scroll_dst = r_cnt - 1'b1;

    always_comb begin
        put_wr   = 1'b0;
        put_addr = cur_addr;
        put_data = {job.attr, job.code};
        col_step = r_col;
        ph_step  = r_phase;
        line     = 1'b0;
        case (job.kind)
            K_BACKSPACE: begin
                // ignored at column 0
                if (r_col != '0) begin
                    col_step = r_col - 1'b1;
                    ph_step  = (r_phase == '0) ? PH_W'(TAB_WIDTH - 1) : r_phase - 1'b1;
                    put_wr   = 1'b1;
                    put_addr = cur_addr - 1'b1;
                    put_data = blank_word(job.attr);
                end
            end
            K_TAB: begin
                col_step = r_col - COL_W'(r_phase) + COL_W'(TAB_WIDTH);
                ph_step  = '0;
            end
            K_NEWLINE: begin
                col_step = '0;
                ph_step  = '0;
                line     = 1'b1;
            end
            K_PRINT: begin
                put_wr   = 1'b1;
                col_step = r_col + 1'b1;
                ph_step  = (r_phase == PH_W'(TAB_WIDTH - 1)) ? '0 : r_phase + 1'b1;
            end
            default: begin
            end
        endcase
        if (col_step >= COL_W'(COLUMNS)) begin
            col_step = '0;
            ph_step  = '0;
            line     = 1'b1;
        end
        n_col    = col_step;
        n_phase  = ph_step;
        n_row    = r_row;
        n_base   = r_base;
        n_scroll = 1'b0;
        if (line) begin
            if (r_row == ROW_W'(ROWS - 1)) begin
                n_scroll = 1'b1;
            end else begin
                n_row  = r_row + 1'b1;
                n_base = r_base + ADDR_W'(COLUMNS);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt[ADDR_W-1:0];
        wr_data = r_fill_word;
        rd_en   = 1'b0;
        rd_addr = idx_wide[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (pop) begin
                    wr_en   = put_wr && (job.kind != K_CLEAR) && (job.kind != K_READ);
                    wr_addr = put_addr;
                    wr_data = put_data;
                    rd_en   = (job.kind == K_READ) && idx_ok;
                end
            end
            S_SCROLL: begin
                // read one row ahead, write back the word read last cycle
                rd_en   = (r_cnt != CNT_W'(SCROLL_END));
                rd_addr = scroll_src[ADDR_W-1:0];
                wr_en   = (r_cnt != '0);
                wr_addr = scroll_dst[ADDR_W-1:0];
                wr_data = rd_data;
            end
            S_FILL, S_BLANK: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    tmcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_cnt        <= '0;
            r_fill_word  <= blank_word(BLANK_ATTR_RESET);
            r_fill_reply <= 1'b0;
            r_init       <= 1'b1;
            r_read_ok    <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_base       <= '0;
            r_phase      <= '0;
            r_out_valid  <= 1'b0;
            r_out_pos    <= '0;
            r_out_word   <= '0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        case (job.kind)
                            K_CLEAR: begin
                                r_col        <= '0;
                                r_row        <= '0;
                                r_base       <= '0;
                                r_phase      <= '0;
                                r_cnt        <= '0;
                                r_fill_word  <= blank_word(i_blank_attr);
                                r_fill_reply <= 1'b1;
                                r_state      <= S_FILL;
                            end
                            K_READ: begin
                                r_read_ok <= idx_ok;
                                r_state   <= S_READ;
                            end
                            default: begin
                                r_col   <= n_col;
                                r_row   <= n_row;
                                r_base  <= n_base;
                                r_phase <= n_phase;
                                if (n_scroll) begin
                                    r_cnt       <= '0;
                                    r_fill_word <= blank_word(i_blank_attr);
                                    r_state     <= S_SCROLL;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out_pos   <= nxt_wide[POS_W-1:0];
                                    r_out_word  <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_pos   <= cur_wide[POS_W-1:0];
                    r_out_word  <= r_read_ok ? rd_data : '0;
                    r_state     <= S_IDLE;
                end
                S_SCROLL: begin
                    if (r_cnt == CNT_W'(SCROLL_END)) begin
                        r_state <= S_BLANK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_BLANK: begin
                    if (r_cnt == CNT_W'(CELL_COUNT - 1)) begin
                        r_out_valid <= 1'b1;
                        r_out_pos   <= cur_wide[POS_W-1:0];
                        r_out_word  <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FILL: begin
                    if (r_cnt == CNT_W'(CELL_COUNT - 1)) begin
                        r_init <= 1'b0;
                        if (r_fill_reply) begin
                            r_out_valid <= 1'b1;
                            r_out_pos   <= cur_wide[POS_W-1:0];
                            r_out_word  <= '0;
                        end
                        r_fill_reply <= 1'b0;
                        r_state      <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_init_busy   = r_init;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_out_word, r_out_pos};

endmodule
